// ===== rtl/core/acc_speed_gap_controller_core_assert.svh =====
// Assertion macros used by the port-level checker of the speed and gap controller.
`ifndef ACC_SPEED_GAP_CONTROLLER_CORE_ASSERT_SVH
`define ACC_SPEED_GAP_CONTROLLER_CORE_ASSERT_SVH

// Checked on every rising edge while the design is out of reset.
`define ACSG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ACSG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/acsg_pkg.sv =====
// Package with widths, constants, types and the microcode table of the speed and gap controller.
`default_nettype none

package acsg_pkg;

    localparam int GAIN_W     = 16;
    localparam int HW_W       = 15;
    localparam int SPD_W      = 15;
    localparam int GAP_W      = 17;
    localparam int ACCEL_W    = 16;
    localparam int LAW_W      = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int REL_W      = 17;
    localparam int OPA_W      = 20;
    localparam int OPB_W      = 18;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 40;
    localparam int FRAC_Q12   = 12;
    localparam int RND_W      = ACC_W - FRAC_Q12;
    localparam int PC_W       = 4;
    localparam int SUM_W      = SPD_W + 1;

    localparam int unsigned STEP_LENGTH_Q12_DEF = 4096;

    localparam logic signed [GAP_W-1:0] GAP_SPEED_LAW = 17'sd30720;
    localparam logic signed [GAP_W-1:0] GAP_GAP_LAW   = 17'sd25600;
    localparam logic signed [OPA_W-1:0] SPACE_TOL     = 20'sd51;
    localparam logic signed [REL_W-1:0] VERR_TOL      = 17'sd25;
    localparam logic [SUM_W-1:0]        OVR_MARGIN    = 16'd512;
    localparam logic signed [RND_W-1:0] SPEED_MAX     = 28'sd32767;
    localparam logic signed [RND_W-1:0] ACCEL_MAX     = 28'sd32767;
    localparam logic signed [RND_W-1:0] ACCEL_MIN     = -28'sd32768;
    localparam logic signed [ACC_W-1:0] ROUND_HALF    = 40'sd2048;

    localparam logic signed [GAIN_W-1:0] RST_SPEED_GAIN         = -16'sd1638;
    localparam logic signed [GAIN_W-1:0] RST_CLOSING_GAIN_SPEED = 16'sd3277;
    localparam logic signed [GAIN_W-1:0] RST_CLOSING_GAIN_SPACE = 16'sd164;
    localparam logic signed [GAIN_W-1:0] RST_KEEP_GAIN_SPEED    = 16'sd287;
    localparam logic signed [GAIN_W-1:0] RST_KEEP_GAIN_SPACE    = 16'sd942;
    localparam logic signed [GAIN_W-1:0] RST_AVOID_GAIN_SPEED   = 16'sd942;
    localparam logic signed [GAIN_W-1:0] RST_AVOID_GAIN_SPACE   = 16'sd3277;
    localparam logic [HW_W-1:0]          RST_HEADWAY_TIME       = 15'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_GAIN         = 4'd0,
        REG_CLOSING_GAIN_SPEED = 4'd1,
        REG_CLOSING_GAIN_SPACE = 4'd2,
        REG_KEEP_GAIN_SPEED    = 4'd3,
        REG_KEEP_GAIN_SPACE    = 4'd4,
        REG_AVOID_GAIN_SPEED   = 4'd5,
        REG_AVOID_GAIN_SPACE   = 4'd6,
        REG_HEADWAY_TIME       = 4'd7
    } t_reg_idx;

    typedef enum logic [LAW_W-1:0] {
        LAW_SPEED = 2'd0,
        LAW_KEEP  = 2'd1,
        LAW_AVOID = 2'd2,
        LAW_CLOSE = 2'd3
    } t_law;

    typedef enum logic [2:0] {
        OPA_OWN,
        OPA_VERR,
        OPA_DV,
        OPA_SPACING,
        OPA_ACCEL
    } t_opa;

    typedef enum logic [2:0] {
        OPB_HEADWAY,
        OPB_SPEED_GAIN,
        OPB_GAIN_SPEED,
        OPB_GAIN_SPACE,
        OPB_STEP
    } t_opb;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_accop;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_SPEED_LAW
    } t_jmp;

    typedef struct packed {
        t_opa            opa;
        t_opb            opb;
        t_accop          acc_op;
        logic            spacing_en;
        logic            law_en;
        logic            accel_en;
        logic            finish;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    localparam logic [PC_W-1:0] UPC_MODE       = 4'd0;
    localparam logic [PC_W-1:0] UPC_SPACING    = 4'd1;
    localparam logic [PC_W-1:0] UPC_PICK       = 4'd2;
    localparam logic [PC_W-1:0] UPC_REL_SPEED  = 4'd3;
    localparam logic [PC_W-1:0] UPC_SPACE_TERM = 4'd4;
    localparam logic [PC_W-1:0] UPC_ACCEL      = 4'd5;
    localparam logic [PC_W-1:0] UPC_SPEED      = 4'd6;
    localparam logic [PC_W-1:0] UPC_STEP       = 4'd7;
    localparam logic [PC_W-1:0] UPC_FINISH     = 4'd8;

    localparam t_uword UWORD_NOP = '{
        opa: OPA_OWN, opb: OPB_HEADWAY, acc_op: ACC_HOLD, spacing_en: 1'b0,
        law_en: 1'b0, accel_en: 1'b0, finish: 1'b0, jmp: JMP_NONE, target: '0
    };

    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = UWORD_NOP;
        unique case (pc)
            UPC_MODE: begin
                w.opa    = OPA_OWN;
                w.opb    = OPB_HEADWAY;
                w.acc_op = ACC_LOAD;
                w.jmp    = JMP_SPEED_LAW;
                w.target = UPC_SPEED;
            end
            UPC_SPACING: begin
                w.spacing_en = 1'b1;
            end
            UPC_PICK: begin
                w.law_en = 1'b1;
            end
            UPC_REL_SPEED: begin
                w.opa    = OPA_DV;
                w.opb    = OPB_GAIN_SPEED;
                w.acc_op = ACC_LOAD;
            end
            UPC_SPACE_TERM: begin
                w.opa    = OPA_SPACING;
                w.opb    = OPB_GAIN_SPACE;
                w.acc_op = ACC_ADD;
            end
            UPC_ACCEL: begin
                w.accel_en = 1'b1;
                w.jmp      = JMP_ALWAYS;
                w.target   = UPC_STEP;
            end
            UPC_SPEED: begin
                w.opa    = OPA_VERR;
                w.opb    = OPB_SPEED_GAIN;
                w.acc_op = ACC_LOAD;
                w.jmp    = JMP_ALWAYS;
                w.target = UPC_ACCEL;
            end
            UPC_STEP: begin
                w.opa    = OPA_ACCEL;
                w.opb    = OPB_STEP;
                w.acc_op = ACC_LOAD;
            end
            UPC_FINISH: begin
                w.finish = 1'b1;
            end
            default: begin
                w.jmp    = JMP_ALWAYS;
                w.target = UPC_FINISH;
            end
        endcase
        return w;
    endfunction

    // Round to nearest, ties toward plus infinity, then drop twelve fraction bits.
    function automatic logic signed [RND_W-1:0] round_q12(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] t;
        t = x + ROUND_HALF;
        return RND_W'(t >>> FRAC_Q12);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acsg_in_if.sv =====
// Input channel interface: one control step request per word.
`default_nettype none

interface acsg_in_if;
    import acsg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SPD_W-1:0]        own_speed;
    logic signed [GAP_W-1:0] gap_ahead;
    logic [SPD_W-1:0]        leader_speed;
    logic [SPD_W-1:0]        desired_speed;
    logic [SPD_W-1:0]        safe_speed;

    modport source (
        output valid, own_speed, gap_ahead, leader_speed, desired_speed, safe_speed,
        input  ready
    );
    modport sink (
        input  valid, own_speed, gap_ahead, leader_speed, desired_speed, safe_speed,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/acsg_out_if.sv =====
// Output channel interface: one control step result per word.
`default_nettype none

interface acsg_out_if;
    import acsg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [SPD_W-1:0]          next_speed;
    logic signed [ACCEL_W-1:0] accel_cmd;
    logic [LAW_W-1:0]          law_used;
    logic                      override_hit;

    modport source (
        output valid, next_speed, accel_cmd, law_used, override_hit,
        input  ready
    );
    modport sink (
        input  valid, next_speed, accel_cmd, law_used, override_hit,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/acsg_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
`default_nettype none

interface acsg_cfg_if;
    import acsg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acc_speed_gap_controller_core.sv =====
// Top level of the speed and gap controller: microcoded sequencer around one shared multiplier.
//
//   Channel  Dir  Handshake            Word
//   i_in     in   valid/ready          own, gap, leader, desired and safe speed
//   o_out    out  valid/ready          next speed, accel, law, override flag
//   i_cfg    in   valid/ready (ready=1) register index and write data
//
// On the speed law the microcode skips the spacing, law pick, relative speed and space term steps.
// The microcode walks its multiply-accumulates one at a time through a single 20x18 multiplier.
// The next word is accepted once the result is written to the output register.
// The sequencer stalls on its last step only while the output register is still full.
// Synchronous reset restores the register defaults and selects the speed law.
`default_nettype none

module acc_speed_gap_controller_core #(
    parameter int unsigned STEP_LENGTH_Q12 = acsg_pkg::STEP_LENGTH_Q12_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acsg_in_if.sink    i_in,
    acsg_out_if.source o_out,
    acsg_cfg_if.sink   i_cfg
);
    import acsg_pkg::*;

    localparam logic signed [OPB_W-1:0] STEP_B = OPB_W'(STEP_LENGTH_Q12);

    logic signed [GAIN_W-1:0] r_speed_gain;
    logic signed [GAIN_W-1:0] r_closing_gain_speed;
    logic signed [GAIN_W-1:0] r_closing_gain_space;
    logic signed [GAIN_W-1:0] r_keep_gain_speed;
    logic signed [GAIN_W-1:0] r_keep_gain_space;
    logic signed [GAIN_W-1:0] r_avoid_gain_speed;
    logic signed [GAIN_W-1:0] r_avoid_gain_space;
    logic [HW_W-1:0]          r_headway_time;

    logic                      r_gap_mode;
    logic                      n_gap_mode;
    logic                      r_busy;
    logic [PC_W-1:0]           r_pc;
    logic [PC_W-1:0]           n_pc;
    logic [SPD_W-1:0]          r_own;
    logic signed [GAP_W-1:0]   r_gap;
    logic [SPD_W-1:0]          r_safe;
    logic signed [REL_W-1:0]   r_verr;
    logic signed [REL_W-1:0]   r_dv;
    logic signed [OPA_W-1:0]   r_spacing;
    t_law                      r_law;
    t_law                      n_law;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACCEL_W-1:0] r_accel;
    logic signed [ACCEL_W-1:0] n_accel;

    logic                      r_out_valid;
    logic [SPD_W-1:0]          r_next_speed;
    logic signed [ACCEL_W-1:0] r_accel_cmd;
    t_law                      r_law_used;
    logic                      r_override_hit;
    logic [SPD_W-1:0]          n_next_speed;
    logic                      n_override_hit;

    t_uword                    uw;
    logic                      in_fire;
    logic                      stall;
    logic                      advance;
    logic signed [OPA_W-1:0]   opa;
    logic signed [OPB_W-1:0]   opb;
    logic signed [PROD_W-1:0]  prod;
    logic signed [RND_W-1:0]   rnd;
    logic signed [RND_W-1:0]   vsum;
    logic [SPD_W-1:0]          vclamp;
    logic [SUM_W-1:0]          cap;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain         <= RST_SPEED_GAIN;
            r_closing_gain_speed <= RST_CLOSING_GAIN_SPEED;
            r_closing_gain_space <= RST_CLOSING_GAIN_SPACE;
            r_keep_gain_speed    <= RST_KEEP_GAIN_SPEED;
            r_keep_gain_space    <= RST_KEEP_GAIN_SPACE;
            r_avoid_gain_speed   <= RST_AVOID_GAIN_SPEED;
            r_avoid_gain_space   <= RST_AVOID_GAIN_SPACE;
            r_headway_time       <= RST_HEADWAY_TIME;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_SPEED_GAIN:         r_speed_gain         <= $signed(i_cfg.data);
                REG_CLOSING_GAIN_SPEED: r_closing_gain_speed <= $signed(i_cfg.data);
                REG_CLOSING_GAIN_SPACE: r_closing_gain_space <= $signed(i_cfg.data);
                REG_KEEP_GAIN_SPEED:    r_keep_gain_speed    <= $signed(i_cfg.data);
                REG_KEEP_GAIN_SPACE:    r_keep_gain_space    <= $signed(i_cfg.data);
                REG_AVOID_GAIN_SPEED:   r_avoid_gain_speed   <= $signed(i_cfg.data);
                REG_AVOID_GAIN_SPACE:   r_avoid_gain_space   <= $signed(i_cfg.data);
                REG_HEADWAY_TIME:       r_headway_time       <= i_cfg.data[HW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = !r_busy;
    assign in_fire    = i_in.valid && !r_busy;

    always_comb begin
        priority if (i_in.gap_ahead > GAP_SPEED_LAW) begin
            n_gap_mode = 1'b0;
        end else if (i_in.gap_ahead < GAP_GAP_LAW) begin
            n_gap_mode = 1'b1;
        end else begin
            n_gap_mode = r_gap_mode;
        end
    end

    assign uw      = ucode_rom(r_pc);
    assign stall   = uw.finish && r_out_valid && !o_out.ready;
    assign advance = r_busy && !stall;

    always_comb begin
        unique case (uw.jmp)
            JMP_ALWAYS:    n_pc = uw.target;
            JMP_SPEED_LAW: n_pc = r_gap_mode ? r_pc + 1'b1 : uw.target;
            default:       n_pc = r_pc + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pc       <= UPC_MODE;
            r_gap_mode <= 1'b0;
        end else if (in_fire) begin
            r_busy     <= 1'b1;
            r_pc       <= UPC_MODE;
            r_gap_mode <= n_gap_mode;
        end else if (advance) begin
            if (uw.finish) begin
                r_busy <= 1'b0;
            end
            r_pc <= n_pc;
        end
    end

    always_comb begin
        unique case (uw.opa)
            OPA_OWN:     opa = OPA_W'($signed({1'b0, r_own}));
            OPA_VERR:    opa = OPA_W'(r_verr);
            OPA_DV:      opa = OPA_W'(r_dv);
            OPA_SPACING: opa = r_spacing;
            OPA_ACCEL:   opa = OPA_W'(r_accel);
            default:     opa = '0;
        endcase
    end

    always_comb begin
        unique case (uw.opb)
            OPB_HEADWAY:    opb = OPB_W'($signed({1'b0, r_headway_time}));
            OPB_SPEED_GAIN: opb = OPB_W'(r_speed_gain);
            OPB_GAIN_SPEED: begin
                unique case (r_law)
                    LAW_KEEP:  opb = OPB_W'(r_keep_gain_speed);
                    LAW_AVOID: opb = OPB_W'(r_avoid_gain_speed);
                    default:   opb = OPB_W'(r_closing_gain_speed);
                endcase
            end
            OPB_GAIN_SPACE: begin
                unique case (r_law)
                    LAW_KEEP:  opb = OPB_W'(r_keep_gain_space);
                    LAW_AVOID: opb = OPB_W'(r_avoid_gain_space);
                    default:   opb = OPB_W'(r_closing_gain_space);
                endcase
            end
            OPB_STEP: opb = STEP_B;
            default:  opb = '0;
        endcase
    end

    assign prod = opa * opb;
    assign rnd  = round_q12(r_acc);

    always_comb begin
        priority if (r_spacing >= -SPACE_TOL && r_spacing <= SPACE_TOL &&
                     r_verr >= -VERR_TOL && r_verr <= VERR_TOL) begin
            n_law = LAW_KEEP;
        end else if (r_spacing < 0) begin
            n_law = LAW_AVOID;
        end else begin
            n_law = LAW_CLOSE;
        end
    end

    always_comb begin
        priority if (rnd > ACCEL_MAX) begin
            n_accel = ACCEL_W'(ACCEL_MAX);
        end else if (rnd < ACCEL_MIN) begin
            n_accel = ACCEL_W'(ACCEL_MIN);
        end else begin
            n_accel = rnd[ACCEL_W-1:0];
        end
    end

    always_comb begin
        vsum = rnd + RND_W'($signed({1'b0, r_own}));
        priority if (vsum < 0) begin
            vclamp = '0;
        end else if (vsum > SPEED_MAX) begin
            vclamp = SPD_W'(SPEED_MAX);
        end else begin
            vclamp = vsum[SPD_W-1:0];
        end
        cap = {1'b0, r_safe} + OVR_MARGIN;
        if (cap < {1'b0, vclamp}) begin
            n_next_speed   = cap[SPD_W-1:0];
            n_override_hit = 1'b1;
        end else begin
            n_next_speed   = vclamp;
            n_override_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_own  <= i_in.own_speed;
            r_gap  <= i_in.gap_ahead;
            r_safe <= i_in.safe_speed;
            r_verr <= $signed({2'b00, i_in.own_speed}) - $signed({2'b00, i_in.desired_speed});
            r_dv   <= $signed({2'b00, i_in.leader_speed}) - $signed({2'b00, i_in.own_speed});
            r_law  <= LAW_SPEED;
        end else if (advance) begin
            unique case (uw.acc_op)
                ACC_LOAD: r_acc <= ACC_W'(prod);
                ACC_ADD:  r_acc <= r_acc + ACC_W'(prod);
                default: begin
                end
            endcase
            if (uw.spacing_en) begin
                r_spacing <= OPA_W'(r_gap) - OPA_W'(rnd);
            end
            if (uw.law_en) begin
                r_law <= n_law;
            end
            if (uw.accel_en) begin
                r_accel <= n_accel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && uw.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && uw.finish) begin
            r_next_speed   <= n_next_speed;
            r_accel_cmd    <= r_accel;
            r_law_used     <= r_law;
            r_override_hit <= n_override_hit;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.next_speed   = r_next_speed;
    assign o_out.accel_cmd    = r_accel_cmd;
    assign o_out.law_used     = r_law_used;
    assign o_out.override_hit = r_override_hit;

endmodule

`default_nettype wire

// ===== rtl/core/acsg_checker.sv =====
// Port-level checker for the speed and gap controller, bound to the top level.
`default_nettype none
`include "acc_speed_gap_controller_core_assert.svh"

module acsg_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [acsg_pkg::SPD_W-1:0]          i_out_next_speed,
    input logic signed [acsg_pkg::ACCEL_W-1:0] i_out_accel_cmd,
    input logic [acsg_pkg::LAW_W-1:0]          i_out_law_used,
    input logic                                i_out_override_hit
);
    import acsg_pkg::*;

    `ACSG_ASSERT(a_out_valid_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid,
        "result word dropped while stalled")
    `ACSG_ASSERT(a_out_data_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> $stable(i_out_next_speed) &&
        $stable(i_out_accel_cmd) && $stable(i_out_law_used) && $stable(i_out_override_hit),
        "result word changed while stalled")
    `ACSG_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && i_in_ready |=> !i_in_ready,
        "second word taken while a step is running")
    `ACSG_ASSERT(a_override_floor, i_clk, i_rst_n,
        i_out_valid && i_out_override_hit |-> i_out_next_speed >= OVR_MARGIN[SPD_W-1:0],
        "override speed below the cap margin")
    `ACSG_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid,
        "result valid after reset")

endmodule

bind acc_speed_gap_controller_core acsg_checker u_acsg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_next_speed   (o_out.next_speed),
    .i_out_accel_cmd    (o_out.accel_cmd),
    .i_out_law_used     (o_out.law_used),
    .i_out_override_hit (o_out.override_hit)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of the speed and gap controller core: directed steps, then random steps.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acsg_pkg::*;

    localparam int STALL_LIMIT        = 5000;
    localparam int DRAIN_CYCLES       = 24;
    localparam int HOLD_CYCLES        = 400;
    localparam int PHASE_STEPS        = 180;
    localparam int NUM_PHASES         = 6;
    localparam int NUM_ROWS           = 23;
    localparam int FRAC_BITS          = 12;
    localparam int SPEED_LAW_ABOVE    = 30720;
    localparam int GAP_LAW_BELOW      = 25600;
    localparam int SPACING_BAND       = 51;
    localparam int SPEED_ERR_BAND     = 25;
    localparam int CAP_MARGIN         = 512;
    localparam int SPEED_FIELD_TOP    = 25600;
    localparam int GAP_FIELD_TOP      = 65535;
    localparam int GAP_FIELD_BOTTOM   = -2048;
    localparam int KEEP_GAP_CEILING   = 25000;
    localparam longint STEP_Q12       = longint'(STEP_LENGTH_Q12_DEF);
    localparam longint HALF_LSB_Q12   = 2048;
    localparam longint SPEED_TOP      = 32767;
    localparam longint ACCEL_TOP      = 32767;
    localparam longint ACCEL_BOTTOM   = -32768;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

    typedef enum {
        SET_DEFAULT,
        SET_TYPICAL,
        SET_MAX,
        SET_MIN,
        SET_ANY,
        SET_ZERO
    } t_setting;

    typedef struct packed {
        logic [SPD_W-1:0]        own;
        logic signed [GAP_W-1:0] gap;
        logic [SPD_W-1:0]        lead;
        logic [SPD_W-1:0]        desired;
        logic [SPD_W-1:0]        safe;
    } t_step_word;

    typedef struct packed {
        logic [SPD_W-1:0]          speed;
        logic signed [ACCEL_W-1:0] accel;
        t_law                      law;
        logic                      capped;
    } t_speed_command;

    typedef struct packed {
        t_step_word     word;
        logic           typed;
        t_speed_command command;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    acsg_in_if  step_bus();
    acsg_out_if command_bus();
    acsg_cfg_if reg_bus();

    acc_speed_gap_controller_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (step_bus),
        .o_out   (command_bus),
        .i_cfg   (reg_bus)
    );

    logic signed [GAIN_W-1:0] gain_speed_law;
    logic signed [GAIN_W-1:0] close_speed;
    logic signed [GAIN_W-1:0] close_space;
    logic signed [GAIN_W-1:0] keep_speed;
    logic signed [GAIN_W-1:0] keep_space;
    logic signed [GAIN_W-1:0] avoid_speed;
    logic signed [GAIN_W-1:0] avoid_space;
    logic [HW_W-1:0]          headway;
    logic                     gap_law_mode;

    t_speed_command due_commands[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int steps_sent;
    int commands_checked;
    int caps_taken;
    int failures;
    int law_count[4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rounded_q12(input longint x);
        return (x + HALF_LSB_Q12) >>> FRAC_BITS;
    endfunction

    function automatic t_speed_command control_step(input t_step_word w, input logic mode_in,
                                                    output logic mode_out);
        longint own, gap, verr, spacing, dv, gs, gp, accel, vnew, cap;
        t_speed_command r;
        own  = longint'(w.own);
        gap  = longint'($signed(w.gap));
        verr = own - longint'(w.desired);
        mode_out = mode_in;
        if (gap > SPEED_LAW_ABOVE) begin
            mode_out = 1'b0;
        end else if (gap < GAP_LAW_BELOW) begin
            mode_out = 1'b1;
        end
        r.capped = 1'b0;
        if (!mode_out) begin
            accel = rounded_q12(longint'(gain_speed_law) * verr);
            r.law = LAW_SPEED;
        end else begin
            spacing = gap - rounded_q12(longint'(headway) * own);
            dv = longint'(w.lead) - own;
            if ((spacing < 0 ? -spacing : spacing) <= SPACING_BAND &&
                (verr < 0 ? -verr : verr) <= SPEED_ERR_BAND) begin
                gs = keep_speed;
                gp = keep_space;
                r.law = LAW_KEEP;
            end else if (spacing < 0) begin
                gs = avoid_speed;
                gp = avoid_space;
                r.law = LAW_AVOID;
            end else begin
                gs = close_speed;
                gp = close_space;
                r.law = LAW_CLOSE;
            end
            accel = rounded_q12(gs * dv + gp * spacing);
        end
        if (accel > ACCEL_TOP) accel = ACCEL_TOP;
        if (accel < ACCEL_BOTTOM) accel = ACCEL_BOTTOM;
        vnew = own + rounded_q12(accel * STEP_Q12);
        if (vnew < 0) vnew = 0;
        if (vnew > SPEED_TOP) vnew = SPEED_TOP;
        cap = longint'(w.safe) + CAP_MARGIN;
        if (cap < vnew) begin
            vnew = cap;
            r.capped = 1'b1;
        end
        r.speed = vnew[SPD_W-1:0];
        r.accel = accel[ACCEL_W-1:0];
        return r;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SPEED_GAIN:         gain_speed_law = data;
            REG_CLOSING_GAIN_SPEED: close_speed = data;
            REG_CLOSING_GAIN_SPACE: close_space = data;
            REG_KEEP_GAIN_SPEED:    keep_speed = data;
            REG_KEEP_GAIN_SPACE:    keep_space = data;
            REG_AVOID_GAIN_SPEED:   avoid_speed = data;
            REG_AVOID_GAIN_SPACE:   avoid_space = data;
            REG_HEADWAY_TIME:       headway = data[HW_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_directed_row step_row(input int own, input int gap, input int lead,
                                               input int desired, input int safe,
                                               input logic typed, input int speed,
                                               input int accel, input t_law law,
                                               input logic capped);
        t_directed_row row;
        row.word.own        = SPD_W'(own);
        row.word.gap        = GAP_W'(gap);
        row.word.lead       = SPD_W'(lead);
        row.word.desired    = SPD_W'(desired);
        row.word.safe       = SPD_W'(safe);
        row.typed           = typed;
        row.command.speed   = SPD_W'(speed);
        row.command.accel   = ACCEL_W'(accel);
        row.command.law     = law;
        row.command.capped  = capped;
        return row;
    endfunction

    function automatic t_step_word draw_step();
        t_step_word w;
        t_speed_command probe;
        logic probe_mode;
        longint own, term, bound;
        int kind;
        kind = $urandom_range(99);
        w.own     = SPD_W'($urandom_range(SPEED_FIELD_TOP));
        w.lead    = SPD_W'($urandom_range(SPEED_FIELD_TOP));
        w.desired = SPD_W'($urandom_range(SPEED_FIELD_TOP));
        w.safe    = SPD_W'($urandom_range(SPEED_FIELD_TOP));
        if ($urandom_range(1) == 0) begin
            w.gap = GAP_W'(int'($urandom_range(GAP_LAW_BELOW - GAP_FIELD_BOTTOM))
                           + GAP_FIELD_BOTTOM);
        end else begin
            w.gap = GAP_W'(int'($urandom_range(GAP_FIELD_TOP - GAP_FIELD_BOTTOM))
                           + GAP_FIELD_BOTTOM);
        end
        if (kind < 10) begin
            w.own     = SPD_W'($urandom);
            w.gap     = GAP_W'($urandom);
            w.lead    = SPD_W'($urandom);
            w.desired = SPD_W'($urandom);
            w.safe    = SPD_W'($urandom);
        end else if (kind < 40) begin
            // Steer the step near the headway equilibrium so that gap keeping can be reached.
            own  = longint'(w.own);
            term = rounded_q12(longint'(headway) * own);
            while (term > KEEP_GAP_CEILING) begin
                own  = own / 2;
                term = rounded_q12(longint'(headway) * own);
            end
            w.own = SPD_W'(own);
            w.gap = GAP_W'(term + longint'($urandom_range(2 * SPACING_BAND + 18))
                           - SPACING_BAND - 9);
            bound = own + longint'($urandom_range(2 * SPEED_ERR_BAND + 10)) - SPEED_ERR_BAND - 5;
            if (bound < 0) bound = 0;
            w.desired = SPD_W'(bound);
        end else if (kind < 55) begin
            case ($urandom_range(2))
                0: w.gap = GAP_W'(GAP_LAW_BELOW + int'($urandom_range(6)) - 3);
                1: w.gap = GAP_W'(SPEED_LAW_ABOVE + int'($urandom_range(6)) - 3);
                default: w.gap = GAP_W'(GAP_LAW_BELOW
                                        + int'($urandom_range(SPEED_LAW_ABOVE - GAP_LAW_BELOW)));
            endcase
        end else if (kind < 70) begin
            // Put the safe speed cap right at the speed the controller would command.
            w.safe = SPD_W'(SPEED_TOP);
            probe = control_step(w, gap_law_mode, probe_mode);
            bound = longint'(probe.speed) - CAP_MARGIN + longint'($urandom_range(2)) - 1;
            if (bound < 0) begin
                w.safe = SPD_W'($urandom_range(SPEED_FIELD_TOP));
            end else begin
                w.safe = SPD_W'(bound);
            end
        end
        return w;
    endfunction

    task automatic offer_step(input t_step_word w, input logic typed,
                              input t_speed_command typed_command);
        t_speed_command predicted;
        logic next_mode;
        while ($urandom_range(99) < tx_idle_pct) begin
            step_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        step_bus.valid         <= 1'b1;
        step_bus.own_speed     <= w.own;
        step_bus.gap_ahead     <= w.gap;
        step_bus.leader_speed  <= w.lead;
        step_bus.desired_speed <= w.desired;
        step_bus.safe_speed    <= w.safe;
        do @(posedge i_clk); while (!step_bus.ready);
        predicted = control_step(w, gap_law_mode, next_mode);
        gap_law_mode = next_mode;
        due_commands = {due_commands, (typed ? typed_command : predicted)};
        steps_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        step_bus.valid <= 1'b0;
        while (due_commands.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= data;
        do @(posedge i_clk); while (!reg_bus.ready);
        store_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input t_setting s);
        logic [CFG_DATA_W-1:0] data;
        logic is_headway;
        for (int k = REG_SPEED_GAIN; k <= REG_HEADWAY_TIME; k++) begin
            is_headway = (CFG_IDX_W'(k) == REG_HEADWAY_TIME);
            case (s)
                SET_MAX:     data = is_headway ? 16'hFFFF : 16'h7FFF;
                SET_MIN:     data = is_headway ? 16'h0000 : 16'h8000;
                SET_ZERO:    data = 16'h0000;
                SET_TYPICAL: data = is_headway ? CFG_DATA_W'($urandom_range(12288))
                                               : CFG_DATA_W'(int'($urandom_range(8192)) - 4096);
                default:     data = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_IDX_W'(k), data);
        end
        write_reg(REG_UNUSED_FIRST, CFG_DATA_W'($urandom));
        write_reg(REG_UNUSED_LAST, 16'hFFFF);
        reg_bus.valid <= 1'b0;
    endtask

    initial begin
        command_bus.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                command_bus.ready <= 1'b0;
            end else begin
                command_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_speed_command want;
        if (i_rst_n && command_bus.valid && command_bus.ready) begin
            if (due_commands.size() == 0) begin
                $display("%0t: word with nothing expected: speed %0d accel %0d law %0d cap %0b",
                         $time, command_bus.next_speed, command_bus.accel_cmd,
                         command_bus.law_used, command_bus.override_hit);
                failures++;
            end else begin
                want = due_commands.pop_front();
                commands_checked++;
                law_count[want.law]++;
                if (want.capped) caps_taken++;
                if (command_bus.next_speed !== want.speed) begin
                    $display("%0t: next_speed expected %0d, got %0d",
                             $time, want.speed, command_bus.next_speed);
                    failures++;
                end
                if (command_bus.accel_cmd !== want.accel) begin
                    $display("%0t: accel_cmd expected %0d, got %0d",
                             $time, want.accel, command_bus.accel_cmd);
                    failures++;
                end
                if (command_bus.law_used !== want.law) begin
                    $display("%0t: law_used expected %0d, got %0d",
                             $time, want.law, command_bus.law_used);
                    failures++;
                end
                if (command_bus.override_hit !== want.capped) begin
                    $display("%0t: override_hit expected %0b, got %0b",
                             $time, want.capped, command_bus.override_hit);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((step_bus.valid && step_bus.ready) || (command_bus.valid && command_bus.ready) ||
            (reg_bus.valid && reg_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d still expected",
                     $time, STALL_LIMIT, due_commands.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_directed_row rows[NUM_ROWS];
        t_setting plan[NUM_PHASES];

        i_rst_n                = 1'b0;
        step_bus.valid         = 1'b0;
        step_bus.own_speed     = '0;
        step_bus.gap_ahead     = '0;
        step_bus.leader_speed  = '0;
        step_bus.desired_speed = '0;
        step_bus.safe_speed    = '0;
        reg_bus.valid          = 1'b0;
        reg_bus.index          = '0;
        reg_bus.data           = '0;
        hold_request           = 0;
        quiet_cycles           = 0;
        steps_sent             = 0;
        commands_checked       = 0;
        caps_taken             = 0;
        failures               = 0;
        law_count              = '{0, 0, 0, 0};
        tx_idle_pct            = 37;
        rx_idle_pct            = 46;

        gain_speed_law = -16'sd1638;
        close_speed    = 16'sd3277;
        close_space    = 16'sd164;
        keep_speed     = 16'sd287;
        keep_space     = 16'sd942;
        avoid_speed    = 16'sd942;
        avoid_space    = 16'sd3277;
        headway        = 15'd4096;
        gap_law_mode   = 1'b0;

        plan = '{SET_DEFAULT, SET_TYPICAL, SET_MAX, SET_MIN, SET_ANY, SET_ZERO};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows = '{
            //       own    gap     lead   des    safe   typed speed  accel   law
            step_row(0,     0,      0,     0,     0,     1'b1, 0,     0,      LAW_KEEP,  1'b0),
            step_row(0,     28000,  0,     0,     0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     65535,  0,     0,     0,     1'b1, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     28000,  0,     0,     0,     1'b1, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     30720,  0,     0,     0,     1'b1, 0,     0,      LAW_SPEED, 1'b0),
            step_row(25600, 30721,  0,     0,     0,     1'b1, 512,   -10237, LAW_SPEED, 1'b1),
            step_row(25600, 65535,  0,     25600, 25600, 1'b1, 25600, 0,      LAW_SPEED, 1'b0),
            step_row(512,   40000,  0,     512,   0,     1'b1, 512,   0,      LAW_SPEED, 1'b0),
            step_row(513,   40000,  0,     513,   0,     1'b1, 512,   0,      LAW_SPEED, 1'b1),
            step_row(0,     25600,  0,     100,   0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     25599,  0,     0,     0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     -2048,  0,     0,     0,     1'b1, 0,     -1638,  LAW_AVOID, 1'b0),
            step_row(0,     30720,  0,     0,     0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     51,     0,     25,    0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     52,     0,     25,    0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     51,     0,     26,    0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     -51,    0,     0,     0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(0,     -52,    0,     0,     0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(25,    -26,    25600, 0,     0,     1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(32767, -65536, 32767, 32767, 32767, 1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(32767, 65535,  0,     0,     32767, 1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(32000, 65535,  0,     32767, 32767, 1'b0, 0,     0,      LAW_SPEED, 1'b0),
            step_row(1000,  1000,   30000, 1000,  25600, 1'b0, 0,     0,      LAW_SPEED, 1'b0)
        };

        foreach (rows[i]) begin
            offer_step(rows[i].word, rows[i].typed, rows[i].command);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 2) begin
                tx_idle_pct = 46;
                rx_idle_pct = 37;
            end
            if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_drained();
            if (plan[p] != SET_DEFAULT) begin
                program_regs(plan[p]);
            end
            for (int n = 0; n < PHASE_STEPS; n++) begin
                if (p == 2 && n == 20) begin
                    hold_request = HOLD_CYCLES;
                end
                offer_step(draw_step(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d control steps under %0d register settings, one long output stall.",
                 steps_sent, NUM_PHASES);
        $display("Checked %0d words: speed %0d, keep %0d, avoid %0d, closing %0d, capped %0d.",
                 commands_checked, law_count[LAW_SPEED], law_count[LAW_KEEP],
                 law_count[LAW_AVOID], law_count[LAW_CLOSE], caps_taken);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/acsg_pkg.sv
rtl/core/acsg_in_if.sv
rtl/core/acsg_out_if.sv
rtl/core/acsg_cfg_if.sv
rtl/core/acc_speed_gap_controller_core.sv
rtl/core/acsg_checker.sv
sim/tb_top.sv
